// ----- rtl/mop_pkg.sv -----
// ----------------------------------------------------------------------------
// mop_pkg
// shared types and constants of the moving object pool
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mop_pkg;

    localparam int POOL_SIZE_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WALL_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 3'd4;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SPAWN = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // control broadcast to every cell for one cycle
    typedef struct packed {
        logic       tick;
        logic       spawn;
        logic       clear;
        logic [7:0] wall_left;
        logic [7:0] wall_right;
        logic [7:0] wall_top;
        logic [7:0] wall_bottom;
        logic [7:0] start_x;
        logic [7:0] start_y;
        logic [7:0] vel_x;
        logic [7:0] vel_y;
    } t_cell_ctl;

endpackage

// ----- rtl/mop_cell.sv -----
// ----------------------------------------------------------------------------
// mop_cell
// one pool slot: active flag, position and velocity, free-slot chain link
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mop_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mop_pkg::t_cell_ctl i_ctl,
    input  logic               i_free_before,
    output logic               o_free_before,
    output logic               o_take,
    output logic               o_active
);

    logic       r_active;
    logic [7:0] r_pos_x;
    logic [7:0] r_pos_y;
    logic [7:0] r_vel_x;
    logic [7:0] r_vel_y;

    logic              w_take;
    logic signed [9:0] w_nx;
    logic signed [9:0] w_ny;
    logic              w_out;

    assign w_take        = i_ctl.spawn & ~i_free_before & ~r_active;
    assign o_free_before = i_free_before | ~r_active;
    assign o_take        = w_take;
    assign o_active      = r_active;

    // widened signed step
    assign w_nx = $signed({2'b00, r_pos_x}) + $signed({{2{r_vel_x[7]}}, r_vel_x});
    assign w_ny = $signed({2'b00, r_pos_y}) + $signed({{2{r_vel_y[7]}}, r_vel_y});

    assign w_out = (w_nx < $signed({2'b00, i_ctl.wall_left}))  ||
                   (w_nx > $signed({2'b00, i_ctl.wall_right})) ||
                   (w_ny < $signed({2'b00, i_ctl.wall_top}))   ||
                   (w_ny > $signed({2'b00, i_ctl.wall_bottom}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_ctl.clear) begin
            r_active <= 1'b0;
        end else if (w_take) begin
            r_active <= 1'b1;
        end else if (i_ctl.tick && r_active && w_out) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pos_x <= i_ctl.start_x;
            r_pos_y <= i_ctl.start_y;
            r_vel_x <= i_ctl.vel_x;
            r_vel_y <= i_ctl.vel_y;
        end else if (i_ctl.tick && r_active && !w_out) begin
            r_pos_x <= w_nx[7:0];
            r_pos_y <= w_ny[7:0];
        end
    end

endmodule

// ----- rtl/moving_object_pool.sv -----
// ----------------------------------------------------------------------------
// moving_object_pool
// pool of moving objects kept in a row of slot cells; spawn, tick and clear
// sequence: input beat registered, states EXEC, COUNT, DONE, result register
// new beats wait for IDLE, DONE waits on the output; the active count is
// gathered by a scan over the slot cells, one cell per cycle
// reset: synchronous, all slots free, walls 0..255, speed scale 1
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module moving_object_pool #(
    parameter int POOL_SIZE = mop_pkg::POOL_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mop_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mop_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_cmd,
    input  logic [7:0]                     i_start_x,
    input  logic [7:0]                     i_start_y,
    input  logic signed [7:0]              i_aim_x,
    input  logic signed [7:0]              i_aim_y,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_spawn_ok,
    output logic [3:0]                     o_slot_taken,
    output logic [4:0]                     o_active_count
);

    localparam int IdxW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CntW = $clog2(POOL_SIZE + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_COUNT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [7:0] r_wall_left;
    logic [7:0] r_wall_right;
    logic [7:0] r_wall_top;
    logic [7:0] r_wall_bottom;
    logic [6:0] r_speed_scale;

    logic [1:0] r_cmd;
    logic [7:0] r_start_x;
    logic [7:0] r_start_y;
    logic [7:0] r_aim_x;
    logic [7:0] r_aim_y;

    logic            r_ok;
    logic [IdxW-1:0] r_slot;
    logic [IdxW-1:0] r_idx;
    logic [CntW-1:0] r_cnt;

    logic            r_out_valid;
    logic            r_out_ok;
    logic [IdxW-1:0] r_out_slot;
    logic [CntW-1:0] r_out_cnt;

    mop_pkg::t_cell_ctl    w_ctl;
    logic [POOL_SIZE:0]    w_chain;
    logic [POOL_SIZE-1:0]  w_take;
    logic [POOL_SIZE-1:0]  w_active;
    logic [14:0]           w_prod_x;
    logic [14:0]           w_prod_y;
    logic [IdxW-1:0]       w_slot;
    logic                  w_in_beat;
    logic                  w_out_free;
    logic [IdxW+3:0]       w_slot_ext;
    logic [CntW+4:0]       w_cnt_ext;

    assign w_in_beat  = i_in_valid & o_in_ready;
    assign w_out_free = ~r_out_valid | i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_left   <= 8'd0;
            r_wall_right  <= 8'd255;
            r_wall_top    <= 8'd0;
            r_wall_bottom <= 8'd255;
            r_speed_scale <= 7'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mop_pkg::CFG_WALL_LEFT:   r_wall_left   <= i_cfg_data;
                mop_pkg::CFG_WALL_RIGHT:  r_wall_right  <= i_cfg_data;
                mop_pkg::CFG_WALL_TOP:    r_wall_top    <= i_cfg_data;
                mop_pkg::CFG_WALL_BOTTOM: r_wall_bottom <= i_cfg_data;
                mop_pkg::CFG_SPEED_SCALE: r_speed_scale <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_cmd     <= i_cmd;
            r_start_x <= i_start_x;
            r_start_y <= i_start_y;
            r_aim_x   <= i_aim_x;
            r_aim_y   <= i_aim_y;
        end
    end

    assign w_prod_x = 15'(r_aim_x) * 15'(r_speed_scale);
    assign w_prod_y = 15'(r_aim_y) * 15'(r_speed_scale);

    always_comb begin
        w_ctl             = '0;
        w_ctl.tick        = (r_state == S_EXEC) && (r_cmd == mop_pkg::CMD_TICK);
        w_ctl.spawn       = (r_state == S_EXEC) && (r_cmd == mop_pkg::CMD_SPAWN) &&
                            ((r_aim_x != 8'd0) || (r_aim_y != 8'd0));
        w_ctl.clear       = (r_state == S_EXEC) && (r_cmd == mop_pkg::CMD_CLEAR);
        w_ctl.wall_left   = r_wall_left;
        w_ctl.wall_right  = r_wall_right;
        w_ctl.wall_top    = r_wall_top;
        w_ctl.wall_bottom = r_wall_bottom;
        w_ctl.start_x     = r_start_x;
        w_ctl.start_y     = r_start_y;
        w_ctl.vel_x       = w_prod_x[7:0];
        w_ctl.vel_y       = w_prod_y[7:0];
    end

    // row of slot cells, lowest free slot found along the chain
    assign w_chain[0] = 1'b0;

    for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
        mop_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_free_before (w_chain[g]),
            .o_free_before (w_chain[g+1]),
            .o_take        (w_take[g]),
            .o_active      (w_active[g])
        );
    end

    always_comb begin
        w_slot = '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (w_take[i]) begin
                w_slot = w_slot | IdxW'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_beat) n_state = S_EXEC;
            S_EXEC:  n_state = S_COUNT;
            S_COUNT: if (r_idx == IdxW'(POOL_SIZE - 1)) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // spawn outcome and active count scan
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_ok  <= w_ctl.spawn & (|w_take);
            r_slot <= w_slot;
            r_idx <= '0;
            r_cnt <= '0;
        end else if (r_state == S_COUNT) begin
            r_cnt <= r_cnt + CntW'(w_active[r_idx]);
            r_idx <= r_idx + IdxW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_ok   <= r_ok;
            r_out_slot <= r_slot;
            r_out_cnt  <= r_cnt;
        end
    end

    assign w_slot_ext     = {4'd0, r_out_slot};
    assign w_cnt_ext      = {5'd0, r_out_cnt};
    assign o_out_valid    = r_out_valid;
    assign o_spawn_ok     = r_out_ok;
    assign o_slot_taken   = w_slot_ext[3:0];
    assign o_active_count = w_cnt_ext[4:0];

    a_fail_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_spawn_ok) |-> (o_slot_taken == 4'd0))
        else $error("failed spawn reports a slot");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_cnt <= CntW'(POOL_SIZE)))
        else $error("active count beyond pool size");

    a_beat_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> (r_state == S_EXEC))
        else $error("accepted beat not executed");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");

endmodule
